// File: sv/bitmap_run_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// Bitmap run allocator assertion macros
// Shared forms for the concurrent checks of the allocator. They expect a
// clock named clk and an active-low reset named arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bra_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator package
// Field widths, result status codes, action codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

	localparam int DATA_W   = 32;
	localparam int AMOUNT_W = 7;
	localparam int ITEM_W   = 13;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 3;

	typedef logic [STATUS_W-1:0] bra_status_t;

	localparam bra_status_t STAT_DONE    = 2'd0;
	localparam bra_status_t STAT_NOFIT   = 2'd1;
	localparam bra_status_t STAT_ZERO    = 2'd2;
	localparam bra_status_t STAT_BADFREE = 2'd3;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	localparam logic REG_ITEM_BYTES = 1'b0;
	localparam logic REG_POOL_BASE  = 1'b1;

endpackage

`default_nettype wire

// File: sv/bra_req_if.sv
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel that carries one allocate or free request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bra_req_if
	import bra_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                action;
	logic [AMOUNT_W-1:0] amount;
	logic [DATA_W-1:0]   address;

	modport source (output valid, output action, output amount, output address, input ready);
	modport sink (input valid, input action, input amount, input address, output ready);
endinterface

`default_nettype wire

// File: sv/bra_rsp_if.sv
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel that carries the status and run address of a request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bra_rsp_if
	import bra_pkg::*;
();
	logic              valid;
	logic              ready;
	bra_status_t       status;
	logic [DATA_W-1:0] run_address;

	modport source (output valid, output status, output run_address, input ready);
	modport sink (input valid, input status, input run_address, output ready);
endinterface

`default_nettype wire

// File: sv/bra_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bra_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// File: sv/bitmap_run_allocator_top.sv
// ----------------------------------------------------------------------------
// Bitmap run allocator
// First-fit allocator of consecutive slot runs over a used-bit map in RAM.
// ----------------------------------------------------------------------------
// A request transfer on req asks to allocate a run of amount slots, or to
// free amount slots starting at a byte address. Each request gives exactly
// one response transfer on rsp with a status and, for a successful allocate,
// the byte address of the run. Slot size and pool base are set through the
// APB port; the user must write them only while the block is idle, as the
// block itself does not enforce it. The used bits live in a RAM with one bit
// per slot, visited one slot per cycle. An allocate scans from slot zero
// until the first fitting run is found, then marks it and computes the
// address. A free divides the offset by the slot size one quotient bit per
// cycle, checks and clears the run. A zero or oversized amount, or a free of
// address zero, goes straight to the response state.
// One request is in flight at a time; req.ready is high only when idle.
// After reset the block clears every RAM bit before it takes a request;
// APB writes are taken at any time. A stalled rsp holds its transfer, and a
// finished request waits for the response register to free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_run_allocator_top_macros.svh"

module bitmap_run_allocator_top
	import bra_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	bra_req_if.sink                 req,
	bra_rsp_if.source               rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready
);
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int K_W    = (SLOT_W > 1) ? $clog2(SLOT_W) : 1;
	localparam int PROD_W = SLOT_W + ITEM_W;

	localparam logic [3:0] ST_CLR    = 4'd0;
	localparam logic [3:0] ST_IDLE   = 4'd1;
	localparam logic [3:0] ST_SCAN   = 4'd2;
	localparam logic [3:0] ST_MARK   = 4'd3;
	localparam logic [3:0] ST_MUL    = 4'd4;
	localparam logic [3:0] ST_ADDR   = 4'd5;
	localparam logic [3:0] ST_LAST   = 4'd6;
	localparam logic [3:0] ST_DIV    = 4'd7;
	localparam logic [3:0] ST_RANGE  = 4'd8;
	localparam logic [3:0] ST_VERIFY = 4'd9;
	localparam logic [3:0] ST_FREE   = 4'd10;
	localparam logic [3:0] ST_RESP   = 4'd11;

	logic [3:0]          state_q;
	logic [ITEM_W-1:0]   item_bytes_q;
	logic [DATA_W-1:0]   pool_base_q;
	logic [ITEM_W-1:0]   sz;

	logic [CNT_W-1:0]    rd_ptr_q;
	logic                rd_v_s1;
	logic [SLOT_W-1:0]   idx_s1;
	logic [CNT_W-1:0]    run_len_q;
	logic [CNT_W-1:0]    iss_cnt_q;
	logic [CNT_W-1:0]    chk_cnt_q;
	logic [SLOT_W-1:0]   wr_ptr_q;
	logic [CNT_W-1:0]    wr_cnt_q;
	logic [K_W-1:0]      k_q;
	logic                out_valid_q;

	logic                action_q;
	logic [CNT_W-1:0]    amt_q;
	logic [DATA_W-1:0]   addr_q;
	logic [SLOT_W-1:0]   start_q;
	logic [PROD_W-1:0]   prod_q;
	logic [DATA_W-1:0]   rem_q;
	logic [DATA_W-1:0]   dsh_q;
	logic [SLOT_W-1:0]   q_q;
	bra_status_t         res_status_q;
	logic [DATA_W-1:0]   res_addr_q;
	bra_status_t         out_status_q;
	logic [DATA_W-1:0]   out_addr_q;

	logic                ram_we;
	logic                ram_wdata;
	logic                ram_rdata;
	logic                req_fire;
	logic                cfg_wr;
	logic                amt_over;
	logic [CNT_W-1:0]    new_len;
	logic                found;
	logic [SLOT_W-1:0]   found_start;
	logic [SLOT_W-1:0]   mul_a;
	logic [DATA_W+1:0]   last_addr;
	logic                div_bit;
	logic                resp_load;

	assign sz        = (item_bytes_q == '0) ? ITEM_W'(1) : item_bytes_q;
	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_POOL_BASE) ? pool_base_q : DATA_W'(item_bytes_q);

	assign amt_over    = 32'(req.amount) > 32'(SLOTS);
	assign new_len     = ram_rdata ? '0 : run_len_q + CNT_W'(1);
	assign found       = rd_v_s1 && (new_len == amt_q);
	assign found_start = SLOT_W'(CNT_W'(idx_s1) + CNT_W'(1) - amt_q);
	assign mul_a       = (action_q == ACT_ALLOC) ? start_q : SLOT_W'(SLOTS - 1);
	assign last_addr   = (DATA_W + 2)'(pool_base_q) + (DATA_W + 2)'(prod_q);
	assign div_bit     = rem_q >= dsh_q;
	assign resp_load   = (state_q == ST_RESP) && (!out_valid_q || rsp.ready);

	assign ram_we    = (state_q == ST_CLR) || (state_q == ST_MARK) || (state_q == ST_FREE);
	assign ram_wdata = (state_q == ST_MARK);

	bra_ram #(
		.WIDTH (1),
		.DEPTH (SLOTS)
	) u_used_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (ram_wdata),
		.raddr (rd_ptr_q[SLOT_W-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_bytes_q <= ITEM_W'(1);
			pool_base_q  <= DATA_W'(4096);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ITEM_BYTES: item_bytes_q <= pwdata[ITEM_W-1:0];
				REG_POOL_BASE:  pool_base_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			rd_ptr_q    <= '0;
			rd_v_s1     <= 1'b0;
			run_len_q   <= '0;
			iss_cnt_q   <= '0;
			chk_cnt_q   <= '0;
			wr_ptr_q    <= '0;
			wr_cnt_q    <= CNT_W'(SLOTS);
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= 1'b0;
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					wr_ptr_q <= wr_ptr_q + SLOT_W'(1);
					wr_cnt_q <= wr_cnt_q - CNT_W'(1);
					if (wr_cnt_q == CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						rd_ptr_q  <= '0;
						run_len_q <= '0;
						if (req.action == ACT_ALLOC) begin
							if (req.amount == '0 || amt_over) begin
								state_q <= ST_RESP;
							end else begin
								state_q <= ST_SCAN;
							end
						end else begin
							if (req.address == '0 || req.amount == '0 || amt_over) begin
								state_q <= ST_RESP;
							end else begin
								state_q <= ST_MUL;
							end
						end
					end
				end
				ST_SCAN: begin
					if (rd_ptr_q != CNT_W'(SLOTS)) begin
						rd_ptr_q <= rd_ptr_q + CNT_W'(1);
						rd_v_s1  <= 1'b1;
					end
					if (rd_v_s1) begin
						run_len_q <= new_len;
					end
					if (found) begin
						rd_v_s1  <= 1'b0;
						wr_ptr_q <= found_start;
						wr_cnt_q <= amt_q;
						state_q  <= ST_MARK;
					end else if (rd_v_s1 && idx_s1 == SLOT_W'(SLOTS - 1)) begin
						rd_v_s1 <= 1'b0;
						state_q <= ST_RESP;
					end
				end
				ST_MARK: begin
					wr_ptr_q <= wr_ptr_q + SLOT_W'(1);
					wr_cnt_q <= wr_cnt_q - CNT_W'(1);
					if (wr_cnt_q == CNT_W'(1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= (action_q == ACT_ALLOC) ? ST_ADDR : ST_LAST;
				end
				ST_ADDR: begin
					state_q <= ST_RESP;
				end
				ST_LAST: begin
					k_q <= K_W'(SLOT_W - 1);
					if ((DATA_W + 2)'(addr_q) < (DATA_W + 2)'(pool_base_q) ||
					    (DATA_W + 2)'(addr_q) > last_addr) begin
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					k_q <= k_q - K_W'(1);
					if (k_q == '0) begin
						state_q <= ST_RANGE;
					end
				end
				ST_RANGE: begin
					rd_ptr_q  <= CNT_W'(q_q);
					iss_cnt_q <= amt_q;
					chk_cnt_q <= amt_q;
					if (amt_q > CNT_W'(SLOTS) - CNT_W'(q_q)) begin
						state_q <= ST_RESP;
					end else begin
						state_q <= ST_VERIFY;
					end
				end
				ST_VERIFY: begin
					if (iss_cnt_q != '0) begin
						rd_ptr_q  <= rd_ptr_q + CNT_W'(1);
						iss_cnt_q <= iss_cnt_q - CNT_W'(1);
						rd_v_s1   <= 1'b1;
					end
					if (rd_v_s1) begin
						chk_cnt_q <= chk_cnt_q - CNT_W'(1);
						if (!ram_rdata) begin
							rd_v_s1 <= 1'b0;
							state_q <= ST_RESP;
						end else if (chk_cnt_q == CNT_W'(1)) begin
							rd_v_s1  <= 1'b0;
							wr_ptr_q <= q_q;
							wr_cnt_q <= amt_q;
							state_q  <= ST_FREE;
						end
					end
				end
				ST_FREE: begin
					wr_ptr_q <= wr_ptr_q + SLOT_W'(1);
					wr_cnt_q <= wr_cnt_q - CNT_W'(1);
					if (wr_cnt_q == CNT_W'(1)) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (resp_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_ptr_q[SLOT_W-1:0];
		if (req_fire) begin
			action_q   <= req.action;
			amt_q      <= CNT_W'(req.amount);
			addr_q     <= req.address;
			res_addr_q <= '0;
			if (req.action == ACT_ALLOC) begin
				res_status_q <= (req.amount == '0) ? STAT_ZERO :
				                (amt_over ? STAT_NOFIT : STAT_DONE);
			end else if (req.address == '0 || req.amount == '0) begin
				res_status_q <= STAT_DONE;
			end else begin
				res_status_q <= amt_over ? STAT_BADFREE : STAT_DONE;
			end
		end
		if (state_q == ST_SCAN) begin
			if (found) begin
				start_q <= found_start;
			end else if (rd_v_s1 && idx_s1 == SLOT_W'(SLOTS - 1)) begin
				res_status_q <= STAT_NOFIT;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(sz);
		end
		if (state_q == ST_ADDR) begin
			res_addr_q <= pool_base_q + DATA_W'(prod_q);
		end
		if (state_q == ST_LAST) begin
			rem_q <= addr_q - pool_base_q;
			dsh_q <= DATA_W'(sz) << (SLOT_W - 1);
			q_q   <= '0;
			if ((DATA_W + 2)'(addr_q) < (DATA_W + 2)'(pool_base_q) ||
			    (DATA_W + 2)'(addr_q) > last_addr) begin
				res_status_q <= STAT_BADFREE;
			end
		end
		if (state_q == ST_DIV) begin
			if (div_bit) begin
				rem_q <= rem_q - dsh_q;
			end
			q_q   <= (q_q << 1) | SLOT_W'(div_bit);
			dsh_q <= dsh_q >> 1;
		end
		if (state_q == ST_RANGE && amt_q > CNT_W'(SLOTS) - CNT_W'(q_q)) begin
			res_status_q <= STAT_BADFREE;
		end
		if (state_q == ST_VERIFY && rd_v_s1 && !ram_rdata) begin
			res_status_q <= STAT_BADFREE;
		end
		if (resp_load) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.run_address = out_addr_q;

	`BRA_ASSERT_SAME(a_fail_no_addr, rsp.valid && rsp.status != STAT_DONE, rsp.run_address == '0, "failed request returned a nonzero address")
	`BRA_ASSERT_SAME(a_quot_range, state_q == ST_RANGE, 32'(q_q) < 32'(SLOTS), "free slot index beyond the pool")
	`BRA_ASSERT_SAME(a_rd_ptr_range, state_q == ST_SCAN || state_q == ST_VERIFY, 32'(rd_ptr_q) <= 32'(SLOTS), "read pointer beyond the pool")
	`BRA_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready, state_q != ST_IDLE && !ram_we, "request transfer did not start work")

endmodule

`default_nettype wire
